[src/g3rle_pkg.sv]
package g3rle_pkg;

    localparam int RESULTS_MAX = 3;
    localparam int SLOT_W      = $clog2(RESULTS_MAX);
    localparam int COUNT_W     = $clog2(RESULTS_MAX + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] gray;
        logic [9:0] run_length;
        logic       glyph_done;
        logic       last_of_input;
    } result_t;

    // All results of one byte, packed from slot 0 upward
    typedef struct packed {
        result_t [RESULTS_MAX-1:0] slot;
        logic [COUNT_W-1:0]        count;
    } record_t;

endpackage

[src/g3rle_front.sv]
module g3rle_front
    import g3rle_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            take,
    input  logic [7:0]      data_byte,
    input  logic            cfg_valid,
    input  logic [15:0]     cfg_data,
    output record_t         rec,
    output logic            rec_valid
);

    localparam logic [2:0] ESC_CODE       = 3'd7;
    localparam int         BASE_ONE       = 7;
    localparam int         BASE_TWO       = 14;
    localparam int         BASE_SHORT     = 21;
    localparam int         BASE_LONG      = 84;
    localparam logic [9:0] RUN_OFS_ONE    = 10'd1;
    localparam logic [9:0] RUN_OFS_TWO    = 10'(BASE_ONE + 1);
    localparam logic [9:0] RUN_OFS_THREE  = 10'(BASE_TWO + 1);
    localparam logic [9:0] RUN_OFS_SHORT  = 10'(BASE_SHORT + 1);
    localparam logic [9:0] RUN_OFS_LONG   = 10'(BASE_LONG + 1);

    typedef enum logic [2:0] {
        ESC_IDLE,
        ESC_PFX1,
        ESC_PFX2,
        ESC_PFX3,
        ESC_SHORT_LO,
        ESC_SHORT_HI,
        ESC_LONG_LO,
        ESC_LONG_REST
    } esc_state_t;

    typedef struct packed {
        esc_state_t  stage;
        logic [8:0]  digits;
        logic        emit;
        logic [7:0]  gray;
        logic [9:0]  run;
    } step_t;

    function automatic logic [7:0] palette(input logic [2:0] code);
        logic [7:0] g;
        case (code)
            3'd0:    g = 8'h00;
            3'd1:    g = 8'h5F;
            3'd2:    g = 8'h7F;
            3'd3:    g = 8'h9F;
            3'd4:    g = 8'hBF;
            3'd5:    g = 8'hDF;
            3'd6:    g = 8'hFF;
            default: g = 8'h00;
        endcase
        return g;
    endfunction

    function automatic step_t esc_step(input esc_state_t stage, input logic [8:0] digits,
                                       input logic [2:0] code);
        step_t o;
        logic  fin;
        o.stage  = stage;
        o.digits = digits;
        o.emit   = 1'b0;
        o.gray   = 8'h00;
        o.run    = 10'd0;
        fin      = 1'b0;
        case (stage)
            ESC_IDLE:
            begin
                if (code == ESC_CODE)
                begin
                    o.stage = ESC_PFX1;
                end
                else
                begin
                    o.emit = 1'b1;
                    o.gray = palette(code);
                    o.run  = 10'd1;
                end
            end
            ESC_PFX1:
            begin
                if (code == 3'd0)
                    o.stage = ESC_PFX2;
                else
                begin
                    o.run = {7'd0, code} + RUN_OFS_ONE;
                    fin   = 1'b1;
                end
            end
            ESC_PFX2:
            begin
                if (code == 3'd0)
                    o.stage = ESC_PFX3;
                else
                begin
                    o.run = {7'd0, code} + RUN_OFS_TWO;
                    fin   = 1'b1;
                end
            end
            ESC_PFX3:
            begin
                if (code == 3'd0)
                begin
                    o.stage  = ESC_SHORT_LO;
                    o.digits = 9'd0;
                end
                else
                begin
                    o.run = {7'd0, code} + RUN_OFS_THREE;
                    fin   = 1'b1;
                end
            end
            ESC_SHORT_LO:
            begin
                o.digits = {6'd0, code};
                o.stage  = ESC_SHORT_HI;
            end
            ESC_SHORT_HI:
            begin
                if (code == 3'd0 && digits[2:0] == 3'd0)
                    o.stage = ESC_LONG_LO;
                else
                begin
                    o.run = {4'd0, code, digits[2:0]} + RUN_OFS_SHORT;
                    fin   = 1'b1;
                end
            end
            ESC_LONG_LO:
            begin
                o.digits = {6'd0, code};
                o.stage  = ESC_LONG_REST;
            end
            ESC_LONG_REST:
            begin
                // bit 8 marks that the middle digit is in
                if (!digits[8])
                    o.digits = {1'b1, 2'b00, code, digits[2:0]};
                else
                begin
                    o.run = {1'b0, code, digits[5:0]} + RUN_OFS_LONG;
                    fin   = 1'b1;
                end
            end
            default:
            begin
                o.stage  = ESC_IDLE;
                o.digits = 9'd0;
            end
        endcase
        if (fin)
        begin
            o.emit   = 1'b1;
            o.stage  = ESC_IDLE;
            o.digits = 9'd0;
        end
        return o;
    endfunction

    esc_state_t  stage_reg, stage_next;
    logic [8:0]  digits_reg, digits_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [1:0]  lo_reg, lo_next;
    logic [15:0] pixels_done_reg, pixels_done_next;
    logic [15:0] pixel_total_reg;

    logic [9:0]  buf_in;
    logic        three;
    step_t       st0, st1, st2, st_last;
    logic [2:0]  e, hit, keep;
    logic        exh, any_done;
    logic [15:0] rem;
    logic [10:0] prior1, prior2;
    logic [11:0] s0, s1, s2, sum_all;
    logic [15:0] rm0, rm1, rm2;
    result_t     res [RESULTS_MAX];
    record_t     rec_c;
    logic [COUNT_W-1:0] n;

    always_comb
    begin
        case (cnt_reg)
            2'd0:    buf_in = {2'b00, data_byte};
            2'd1:    buf_in = {1'b0, data_byte, lo_reg[0]};
            default: buf_in = {data_byte, lo_reg};
        endcase
    end

    assign three = (cnt_reg != 2'd0);

    assign st0 = esc_step(stage_reg, digits_reg, buf_in[2:0]);
    assign st1 = esc_step(st0.stage, st0.digits, buf_in[5:3]);
    assign st2 = esc_step(st1.stage, st1.digits, buf_in[8:6]);

    assign e = {st2.emit & three, st1.emit, st0.emit};

    assign exh = (pixels_done_reg >= pixel_total_reg);
    assign rem = pixel_total_reg - pixels_done_reg;

    // running totals of the runs emitted before and including each code
    assign prior1  = e[0] ? {1'b0, st0.run} : 11'd0;
    assign prior2  = prior1 + (e[1] ? {1'b0, st1.run} : 11'd0);
    assign s0      = {2'd0, st0.run};
    assign s1      = {1'b0, prior1} + {2'd0, st1.run};
    assign s2      = {1'b0, prior2} + {2'd0, st2.run};
    assign sum_all = {1'b0, prior2} + (e[2] ? {2'd0, st2.run} : 12'd0);

    assign hit[0] = e[0] & (exh | ({4'd0, s0} >= rem));
    assign hit[1] = e[1] & (exh | ({4'd0, s1} >= rem));
    assign hit[2] = e[2] & (exh | ({4'd0, s2} >= rem));

    assign keep[0] = e[0];
    assign keep[1] = e[1] & ~hit[0];
    assign keep[2] = e[2] & ~hit[0] & ~hit[1];

    assign any_done = |(hit & keep);

    assign rm0 = rem;
    assign rm1 = rem - {5'd0, prior1};
    assign rm2 = rem - {5'd0, prior2};

    always_comb
    begin
        res[0].gray          = st0.gray;
        res[0].run_length    = exh ? 10'd1 : (hit[0] ? rm0[9:0] : st0.run);
        res[0].glyph_done    = hit[0];
        res[0].last_of_input = 1'b0;
        res[1].gray          = st1.gray;
        res[1].run_length    = exh ? 10'd1 : (hit[1] ? rm1[9:0] : st1.run);
        res[1].glyph_done    = hit[1];
        res[1].last_of_input = 1'b0;
        res[2].gray          = st2.gray;
        res[2].run_length    = exh ? 10'd1 : (hit[2] ? rm2[9:0] : st2.run);
        res[2].glyph_done    = hit[2];
        res[2].last_of_input = 1'b0;
    end

    // pack kept results into consecutive slots
    always_comb
    begin
        rec_c = '0;
        n     = '0;
        for (int k = 0; k < RESULTS_MAX; k++)
        begin
            if (keep[k])
            begin
                rec_c.slot[SLOT_W'(n)] = res[k];
                n = n + 1'b1;
            end
        end
        rec_c.count = n;
        if (n != '0)
            rec_c.slot[SLOT_W'(n - 1'b1)].last_of_input = 1'b1;
    end

    assign rec       = rec_c;
    assign rec_valid = take && (rec_c.count != '0);

    assign st_last = three ? st2 : st1;

    always_comb
    begin
        if (any_done)
        begin
            stage_next       = ESC_IDLE;
            digits_next      = 9'd0;
            cnt_next         = 2'd0;
            lo_next          = 2'd0;
            pixels_done_next = 16'd0;
        end
        else
        begin
            stage_next       = st_last.stage;
            digits_next      = st_last.digits;
            pixels_done_next = pixels_done_reg + {4'd0, sum_all};
            case (cnt_reg)
                2'd0:
                begin
                    cnt_next = 2'd2;
                    lo_next  = buf_in[7:6];
                end
                2'd1:
                begin
                    cnt_next = 2'd0;
                    lo_next  = 2'd0;
                end
                default:
                begin
                    cnt_next = 2'd1;
                    lo_next  = {1'b0, buf_in[9]};
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg       <= ESC_IDLE;
            digits_reg      <= 9'd0;
            cnt_reg         <= 2'd0;
            lo_reg          <= 2'd0;
            pixels_done_reg <= 16'd0;
            pixel_total_reg <= 16'd1;
        end
        else
        begin
            if (take)
            begin
                stage_reg       <= stage_next;
                digits_reg      <= digits_next;
                cnt_reg         <= cnt_next;
                lo_reg          <= lo_next;
                pixels_done_reg <= pixels_done_next;
            end
            if (cfg_valid)
                pixel_total_reg <= cfg_data;
        end
    end

endmodule

[src/g3rle_queue.sv]
module g3rle_queue
    import g3rle_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr_en,
    input  record_t wr_data,
    input  logic    rd_en,
    output record_t rd_data,
    output logic    full,
    output logic    avail
);

    record_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign avail   = (count_reg != '0);
    assign rd_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (rd_en)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            case ({wr_en, rd_en})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

[src/g3rle_back.sv]
module g3rle_back
    import g3rle_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  record_t     head,
    input  logic        head_avail,
    output logic        head_pop,
    input  logic        pop,
    output logic        empty,
    output logic [7:0]  gray,
    output logic [7:0]  alpha,
    output logic [9:0]  run_length,
    output logic        glyph_done,
    output logic        last_of_input
);

    logic              out_valid_reg;
    result_t           out_reg;
    logic [SLOT_W-1:0] idx_reg;
    logic              load;
    logic              last_slot;
    result_t           cur;

    assign load      = head_avail && (!out_valid_reg || pop);
    assign last_slot = (COUNT_W'(idx_reg) == head.count - 1'b1);
    assign head_pop  = load && last_slot;

    always_comb
    begin
        cur = head.slot[0];
        for (int k = 0; k < RESULTS_MAX; k++)
        begin
            if (idx_reg == SLOT_W'(k))
                cur = head.slot[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_reg <= cur;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= last_slot ? '0 : idx_reg + 1'b1;
            end
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    assign empty         = !out_valid_reg;
    assign gray          = out_reg.gray;
    assign alpha         = (out_reg.gray != 8'h00) ? 8'hFF : 8'h00;
    assign run_length    = out_reg.run_length;
    assign glyph_done    = out_reg.glyph_done;
    assign last_of_input = out_reg.last_of_input;

endmodule

[src/glyph_3bit_rle_decoder_unit.sv]
// Channel   Handshake              Payload
// input     push / full            data_byte[7:0]
// result    empty / pop            gray, alpha, run_length[9:0], glyph_done, last_of_input
// config    cfg_valid / cfg_ready  cfg_data[15:0] (pixel_total)
//
// A byte is parsed and clipped against the pixel total in the cycle it is taken.
// Its 0 to 3 results go through a two-entry record queue to the output register,
// one result per cycle while the output is popped.
// A result passes a queue entry and then the output register. cfg_ready is always high.
// Async reset clears parse state, pixel count, queue and output; pixel_total = 1.
module glyph_3bit_rle_decoder_unit
    import g3rle_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  gray,
    output logic [7:0]  alpha,
    output logic [9:0]  run_length,
    output logic        glyph_done,
    output logic        last_of_input,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic    take;
    record_t rec;
    logic    rec_valid;
    record_t head;
    logic    head_avail;
    logic    head_pop;

    assign cfg_ready = 1'b1;
    assign take      = push && !full;

    g3rle_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .data_byte (data_byte),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .rec       (rec),
        .rec_valid (rec_valid)
    );

    g3rle_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rec_valid),
        .wr_data (rec),
        .rd_en   (head_pop),
        .rd_data (head),
        .full    (full),
        .avail   (head_avail)
    );

    g3rle_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .head_avail    (head_avail),
        .head_pop      (head_pop),
        .pop           (pop),
        .empty         (empty),
        .gray          (gray),
        .alpha         (alpha),
        .run_length    (run_length),
        .glyph_done    (glyph_done),
        .last_of_input (last_of_input)
    );

    // a full record queue means the output already holds a result
    a_full_has_output: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !empty)
        else $error("record queue full while output empty");

    // glyph end drops the rest of the byte
    a_done_ends_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && glyph_done) |-> last_of_input)
        else $error("glyph_done on a result that is not last of its byte");

    a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (run_length != 10'd0))
        else $error("zero run length");

    // a record with no result never enters the queue
    a_no_empty_record: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid |-> (rec.count != '0) && take)
        else $error("empty record written");

endmodule

[bench/glyph_3bit_rle_decoder_unit_test.sv]
`timescale 1ns / 100ps

module glyph_3bit_rle_decoder_unit_test;

    import g3rle_pkg::RESULTS_MAX;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_SLACK = 6;

    localparam logic [2:0] ESCAPE_CODE = 3'd7;
    localparam logic [2:0] EXTEND_CODE = 3'd0;

    localparam logic [2:0] ESC_IDLE      = 3'd0;
    localparam logic [2:0] ESC_FIRST     = 3'd1;
    localparam logic [2:0] ESC_SECOND    = 3'd2;
    localparam logic [2:0] ESC_THIRD     = 3'd3;
    localparam logic [2:0] ESC_SHORT_LO  = 3'd4;
    localparam logic [2:0] ESC_SHORT_HI  = 3'd5;
    localparam logic [2:0] ESC_LONG_LO   = 3'd6;
    localparam logic [2:0] ESC_LONG_REST = 3'd7;

    localparam int RUN_BASE_ONE   = 7;
    localparam int RUN_BASE_TWO   = 14;
    localparam int RUN_BASE_SHORT = 21;
    localparam int RUN_BASE_LONG  = 84;

    typedef struct packed {
        logic [7:0] gray;
        logic [7:0] alpha;
        logic [9:0] run_length;
        logic       glyph_done;
        logic       last_of_input;
    } pixel_run_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  data_byte;
    logic        empty;
    logic        pop;
    logic [7:0]  gray;
    logic [7:0]  alpha;
    logic [9:0]  run_length;
    logic        glyph_done;
    logic        last_of_input;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    // decoder state as predicted
    logic [15:0] px_total;
    logic [9:0]  bit_buf;
    logic [3:0]  bit_cnt;
    logic [2:0]  esc_stage;
    logic [8:0]  esc_digits;
    logic [15:0] px_done;

    pixel_run_t  byte_res [RESULTS_MAX];
    int          byte_n;
    bit          glyph_cut;
    pixel_run_t  want_q [$];

    // code packer: continuous 3-bit stream cut into bytes
    int          pend_bits;
    int          pend_n;

    bit          steady;
    int          hold_left = 0;
    int          quiet_cycles = 0;
    int          errors = 0;
    int          bytes_sent = 0;
    int          directed_bytes = 0;
    int          results_seen = 0;
    int          glyphs_closed = 0;
    int          totals_tried = 0;

    glyph_3bit_rle_decoder_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .data_byte     (data_byte),
        .empty         (empty),
        .pop           (pop),
        .gray          (gray),
        .alpha         (alpha),
        .run_length    (run_length),
        .glyph_done    (glyph_done),
        .last_of_input (last_of_input),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int idle_gap();
        if (steady || $urandom_range(0, 99) < 60)
            return 0;
        return pause_len();
    endfunction

    function automatic logic [7:0] shade_of(input logic [2:0] code);
        case (code)
            3'd0:    return 8'h00;
            3'd1:    return 8'h5F;
            3'd2:    return 8'h7F;
            3'd3:    return 8'h9F;
            3'd4:    return 8'hBF;
            3'd5:    return 8'hDF;
            default: return 8'hFF;
        endcase
    endfunction

    // Clip one run against the pixel total; returns 1 when the glyph closes.
    function automatic bit emit_run(input logic [7:0] g, input int run);
        int         len;
        bit         fin;
        pixel_run_t r;
        if (px_done >= px_total) begin
            len = 1;
            fin = 1'b1;
        end
        else if (run >= int'(px_total) - int'(px_done)) begin
            len = int'(px_total) - int'(px_done);
            fin = 1'b1;
        end
        else begin
            len = run;
            fin = 1'b0;
        end
        r.gray          = g;
        r.alpha         = (g != 8'h00) ? 8'hFF : 8'h00;
        r.run_length    = len[9:0];
        r.glyph_done    = fin;
        r.last_of_input = 1'b0;
        byte_res[byte_n] = r;
        byte_n++;
        px_done = fin ? 16'd0 : px_done + len[15:0];
        return fin;
    endfunction

    function automatic bit take_code(input logic [2:0] code);
        int run;
        run = 0;
        case (esc_stage)
            ESC_IDLE: begin
                if (code == ESCAPE_CODE) begin
                    esc_stage = ESC_FIRST;
                    return 1'b0;
                end
                return emit_run(shade_of(code), 1);
            end
            ESC_FIRST: begin
                if (code == EXTEND_CODE) begin
                    esc_stage = ESC_SECOND;
                    return 1'b0;
                end
                run = int'(code) + 1;
            end
            ESC_SECOND: begin
                if (code == EXTEND_CODE) begin
                    esc_stage = ESC_THIRD;
                    return 1'b0;
                end
                run = int'(code) + RUN_BASE_ONE + 1;
            end
            ESC_THIRD: begin
                if (code == EXTEND_CODE) begin
                    esc_stage  = ESC_SHORT_LO;
                    esc_digits = '0;
                    return 1'b0;
                end
                run = int'(code) + RUN_BASE_TWO + 1;
            end
            ESC_SHORT_LO: begin
                esc_digits = {6'd0, code};
                esc_stage  = ESC_SHORT_HI;
                return 1'b0;
            end
            ESC_SHORT_HI: begin
                // two zero digits switch to the long form
                if (code == EXTEND_CODE && esc_digits == '0) begin
                    esc_stage = ESC_LONG_LO;
                    return 1'b0;
                end
                run = ((int'(code) << 3) | int'(esc_digits[2:0])) + RUN_BASE_SHORT + 1;
            end
            ESC_LONG_LO: begin
                esc_digits = {6'd0, code};
                esc_stage  = ESC_LONG_REST;
                return 1'b0;
            end
            default: begin
                // top bit of the digits marks the middle digit as taken
                if (!esc_digits[8]) begin
                    esc_digits = {1'b1, 2'b00, code, esc_digits[2:0]};
                    return 1'b0;
                end
                run = ((int'(code) << 6) | int'(esc_digits[5:0])) + RUN_BASE_LONG + 1;
            end
        endcase
        esc_stage  = ESC_IDLE;
        esc_digits = '0;
        return emit_run(8'h00, run);
    endfunction

    function automatic void decode_byte(input logic [7:0] b);
        int         cnt;
        int         bits;
        bit         cut;
        pixel_run_t r;
        cnt  = (bit_cnt > 4'd2) ? 2 : int'(bit_cnt);
        bits = (int'(bit_buf) & ((1 << cnt) - 1)) | (int'(b) << cnt);
        cnt += 8;
        byte_n = 0;
        cut = 1'b0;
        while (cnt >= 3 && !cut) begin
            cnt -= 3;
            if (take_code(bits[2:0])) begin
                // drop what is left of the byte
                cut        = 1'b1;
                bits       = 0;
                cnt        = 0;
                esc_stage  = ESC_IDLE;
                esc_digits = '0;
            end
            else begin
                bits = bits >> 3;
            end
        end
        bit_buf = bits[9:0];
        bit_cnt = cnt[3:0];
        for (int i = 0; i < byte_n; i++) begin
            r = byte_res[i];
            r.last_of_input = (i == byte_n - 1);
            if (r.glyph_done)
                glyphs_closed++;
            want_q.push_back(r);
        end
        glyph_cut = cut;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        @(negedge clk);
        gap = idle_gap();
        if (gap > 0) begin
            push = 1'b0;
            repeat (gap) @(negedge clk);
        end
        push      = 1'b1;
        data_byte = b;
        do
            @(posedge clk);
        while (full);
        decode_byte(b);
        bytes_sent++;
    endtask

    task automatic pack_code(input logic [2:0] c);
        pend_bits = pend_bits | (int'(c) << pend_n);
        pend_n += 3;
        if (pend_n >= 8) begin
            send_byte(pend_bits[7:0]);
            pend_bits = pend_bits >> 8;
            pend_n -= 8;
            if (glyph_cut) begin
                pend_bits = 0;
                pend_n    = 0;
            end
        end
    endtask

    // Pad with zero codes until the stream sits on a byte boundary.
    task automatic pack_flush();
        while (pend_n != 0)
            pack_code(3'd0);
    endtask

    task automatic settle();
        @(negedge clk);
        push = 1'b0;
        while (want_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    task automatic write_total(input logic [15:0] v);
        @(negedge clk);
        push      = 1'b0;
        cfg_valid = 1'b1;
        cfg_data  = v;
        do
            @(posedge clk);
        while (!cfg_ready);
        px_total = v;
        totals_tried++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic pack_random_token();
        int         kind;
        logic [2:0] d0;
        logic [2:0] d1;
        kind = $urandom_range(0, 99);
        if (kind < 45) begin
            pack_code(3'($urandom_range(0, 6)));
        end
        else begin
            pack_code(ESCAPE_CODE);
            if (kind < 55) begin
                pack_code(3'($urandom_range(1, 7)));
            end
            else if (kind < 65) begin
                pack_code(EXTEND_CODE);
                pack_code(3'($urandom_range(1, 7)));
            end
            else if (kind < 75) begin
                pack_code(EXTEND_CODE);
                pack_code(EXTEND_CODE);
                pack_code(3'($urandom_range(1, 7)));
            end
            else if (kind < 88) begin
                repeat (3) pack_code(EXTEND_CODE);
                do begin
                    d0 = 3'($urandom_range(0, 7));
                    d1 = 3'($urandom_range(0, 7));
                end while (d0 == 3'd0 && d1 == 3'd0);
                pack_code(d0);
                pack_code(d1);
            end
            else begin
                repeat (5) pack_code(EXTEND_CODE);
                repeat (3) pack_code(3'($urandom_range(0, 7)));
            end
        end
    endtask

    task automatic random_phase(input logic [15:0] total, input int n_bytes, input bit calm);
        int start;
        settle();
        write_total(total);
        steady = calm;
        start  = bytes_sent;
        while (bytes_sent - start < n_bytes)
            pack_random_token();
        pack_flush();
        steady = 1'b0;
    endtask

    // pixel total still at its reset value: every result closes a glyph
    task automatic test_reset_total();
        send_byte(8'h00);
        send_byte(8'hFF);
    endtask

    task automatic test_code_forms();
        settle();
        write_total(16'hFFFF);
        for (int i = 0; i < 7; i++)
            pack_code(i[2:0]);
        pack_code(ESCAPE_CODE);
        pack_code(3'd1);
        pack_code(ESCAPE_CODE);
        pack_code(3'd7);
        pack_code(ESCAPE_CODE);
        pack_code(EXTEND_CODE);
        pack_code(3'd1);
        pack_code(ESCAPE_CODE);
        repeat (2) pack_code(EXTEND_CODE);
        pack_code(3'd7);
        pack_code(ESCAPE_CODE);
        repeat (3) pack_code(EXTEND_CODE);
        pack_code(3'd1);
        pack_code(3'd0);
        pack_code(ESCAPE_CODE);
        repeat (3) pack_code(EXTEND_CODE);
        pack_code(3'd7);
        pack_code(3'd7);
        pack_code(ESCAPE_CODE);
        repeat (5) pack_code(EXTEND_CODE);
        repeat (3) pack_code(3'd7);
        pack_flush();
    endtask

    task automatic test_run_clip();
        settle();
        write_total(16'd3);
        // close the glyph left open above, then clip a run of 8 to 3
        pack_code(3'd0);
        pack_flush();
        pack_code(ESCAPE_CODE);
        pack_code(3'd7);
        pack_flush();
    endtask

    task automatic test_lowered_total();
        settle();
        write_total(16'd100);
        pack_code(ESCAPE_CODE);
        repeat (2) pack_code(EXTEND_CODE);
        pack_code(3'd7);
        pack_code(3'd1);
        pack_code(3'd2);
        pack_flush();
        settle();
        // glyph already past the new total
        write_total(16'd5);
        pack_code(3'd3);
        pack_flush();
    endtask

    task automatic test_random_glyphs();
        random_phase(16'($urandom_range(1, 8)), 80, 1'b0);
        random_phase(16'($urandom_range(16, 200)), 90, 1'b0);
        random_phase(16'hFFFF, 60, 1'b1);
        random_phase(16'($urandom_range(1, 65535)), 70, 1'b0);
    endtask

    task automatic test_byte_noise();
        settle();
        write_total(16'($urandom_range(1, 40)));
        repeat (80) send_byte(8'($urandom_range(0, 255)));
    endtask

    always @(negedge clk) begin
        if (steady) begin
            pop       = 1'b1;
            hold_left = 0;
        end
        else if (hold_left > 0) begin
            pop = 1'b0;
            hold_left--;
        end
        else begin
            pop = 1'b1;
            if ($urandom_range(0, 3) == 0)
                hold_left = pause_len();
        end
    end

    always @(posedge clk) begin : check_results
        pixel_run_t want;
        if (rst_n && pop && !empty) begin
            results_seen++;
            if (want_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: gray %02h alpha %02h run %0d done %b last %b",
                             gray, alpha, run_length, glyph_done, last_of_input);
            end
            else begin
                want = want_q.pop_front();
                if (gray !== want.gray || alpha !== want.alpha
                    || run_length !== want.run_length || glyph_done !== want.glyph_done
                    || last_of_input !== want.last_of_input) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("mismatch at %0t: want gray %02h alpha %02h run %0d done %b last %b",
                                 $realtime, want.gray, want.alpha, want.run_length,
                                 want.glyph_done, want.last_of_input);
                        $display("    got gray %02h alpha %02h run %0d done %b last %b",
                                 gray, alpha, run_length, glyph_done, last_of_input);
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("no request moved for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, want_q.size());
            $display("glyph_3bit_rle_decoder_unit_test: done, errors");
            $finish;
        end
    end

    initial begin
        rst_n      = 1'b0;
        push       = 1'b0;
        pop        = 1'b0;
        data_byte  = 8'h00;
        cfg_valid  = 1'b0;
        cfg_data   = 16'd0;
        steady     = 1'b0;
        glyph_cut  = 1'b0;
        pend_bits  = 0;
        pend_n     = 0;
        px_total   = 16'd1;
        bit_buf    = '0;
        bit_cnt    = '0;
        esc_stage  = ESC_IDLE;
        esc_digits = '0;
        px_done    = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_total();
        test_code_forms();
        test_run_clip();
        test_lowered_total();
        directed_bytes = bytes_sent;
        test_random_glyphs();
        test_byte_noise();
        settle();
        errors += want_q.size();

        $display("sent %0d bytes (%0d directed), checked %0d results, %0d glyphs closed",
                 bytes_sent, directed_bytes, results_seen, glyphs_closed);
        $display("pixel totals written: %0d, failures: %0d", totals_tried, errors);
        if (errors == 0)
            $display("glyph_3bit_rle_decoder_unit_test: done, clean");
        else
            $display("glyph_3bit_rle_decoder_unit_test: done, errors");
        $finish;
    end

endmodule
